// ===== src/rau_pkg.sv =====
// Shared types and constants of the rational arithmetic unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package rau_pkg;

    // Internal word width of products, sums and the reduction loop.
    localparam int PROD_W    = 64;
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 31;
    localparam int CMD_W     = 3;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int SHIFT_W   = $clog2(PROD_W);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_NORM  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RECIP = 3'd5;
    localparam logic [CMD_W-1:0] CMD_EQ    = 3'd6;

    // Product selectors: an*bd, bn*ad, ad*bd, an*bn.
    localparam logic [1:0] PSEL_AN_BD = 2'd0;
    localparam logic [1:0] PSEL_BN_AD = 2'd1;
    localparam logic [1:0] PSEL_AD_BD = 2'd2;
    localparam logic [1:0] PSEL_AN_BN = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_FORM,
        ST_FIX,
        ST_MAG,
        ST_GCD,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } rau_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       form;
        logic       fix;
        logic       mag;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } rau_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reduce;
        logic gcd_done;
    } rau_status_t;

endpackage

// ===== src/rau_ctrl.sv =====
// Sequencer of the rational arithmetic unit: handshakes and step control.
// Depends on rau_pkg.
module rau_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  rau_pkg::rau_status_t status,
    output rau_pkg::rau_cmd_t    cmd
);
    import rau_pkg::*;

    rau_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(3);

    // State, counter and output flag registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_sel = cnt_reg[1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_FORM;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FORM: begin
                cmd.form   = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_MAG;
            end
            ST_MAG: begin
                cmd.mag    = 1'b1;
                state_next = ST_GCD;
            end
            ST_GCD: begin
                if (!status.reduce) begin
                    state_next = ST_DONE;
                end else if (status.gcd_done) begin
                    state_next = ST_DIV_INIT;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // The output word stays until taken; a new one is loaded only into a free slot.
    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    a_accept_to_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_MUL))
        else $error("accepted word did not start the products");

    a_load_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_ready))
        else $error("output word overwritten before it was taken");

    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GCD) |-> (cnt_reg == '0))
        else $error("step counter not cleared before reduction");

endmodule

// ===== src/rau_dp.sv =====
// Datapath of the rational arithmetic unit: products, sign fix, binary GCD,
// serial division and the output register. Depends on rau_pkg.
module rau_dp #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic [rau_pkg::CMD_W-1:0]           in_cmd,
    input  logic signed [OPERAND_WIDTH-1:0]     in_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]     in_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]     in_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]     in_b_den,
    input  rau_pkg::rau_cmd_t                   cmd,
    output rau_pkg::rau_status_t                status,
    output logic signed [rau_pkg::RES_NUM_W-1:0] result_num,
    output logic [rau_pkg::RES_DEN_W-1:0]       result_den,
    output logic                                zero_den_error,
    output logic                                is_equal
);
    import rau_pkg::*;

    localparam int W = OPERAND_WIDTH;

    logic [CMD_W-1:0]       cmd_reg;
    logic signed [W-1:0]    an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PROD_W-1:0] p_reg [4];
    logic signed [PROD_W-1:0] num_reg, den_reg;
    logic                   form_reg, eq_reg, neg_reg, reduce_reg;
    logic [PROD_W-1:0]      mag_reg, u_reg, v_reg, g_reg;
    logic [SHIFT_W-1:0]     k_reg;
    logic [PROD_W-1:0]      remn_reg, quon_reg, remd_reg, quod_reg;
    logic signed [RES_NUM_W-1:0] rnum_reg;
    logic [RES_DEN_W-1:0]   rden_reg;
    logic                   rerr_reg, req_reg;

    logic signed [W-1:0]    mul_x, mul_y;
    logic signed [2*W-1:0]  prod;
    logic signed [PROD_W-1:0] an_x, ad_x;
    logic signed [PROD_W-1:0] n_form, d_form;
    logic                   form_ok;
    logic signed [PROD_W-1:0] d_fix;
    logic [PROD_W:0]        tn, td;
    logic [PROD_W:0]        g_x;
    logic signed [PROD_W-1:0] num_fin, den_fin;

    // Product operand selection; one multiplication per cycle.
    always_comb begin
        unique case (cmd.mul_sel)
            PSEL_AN_BD: begin mul_x = an_reg; mul_y = bd_reg; end
            PSEL_BN_AD: begin mul_x = bn_reg; mul_y = ad_reg; end
            PSEL_AD_BD: begin mul_x = ad_reg; mul_y = bd_reg; end
            default:    begin mul_x = an_reg; mul_y = bn_reg; end
        endcase
    end
    assign prod = mul_x * mul_y;

    assign an_x = PROD_W'(an_reg);
    assign ad_x = PROD_W'(ad_reg);

    // Raw numerator and denominator for each command.
    always_comb begin
        n_form  = '0;
        d_form  = '0;
        form_ok = 1'b1;
        unique case (cmd_reg)
            CMD_NORM:  begin n_form = an_x;               d_form = ad_x;     end
            CMD_ADD:   begin n_form = p_reg[0] + p_reg[1]; d_form = p_reg[2]; end
            CMD_SUB:   begin n_form = p_reg[0] - p_reg[1]; d_form = p_reg[2]; end
            CMD_MUL:   begin n_form = p_reg[3];           d_form = p_reg[2]; end
            CMD_DIV:   begin n_form = p_reg[0];           d_form = p_reg[1]; end
            CMD_RECIP: begin n_form = ad_x;               d_form = an_x;     end
            default:   form_ok = 1'b0;
        endcase
    end

    assign d_fix = (num_reg == '0) ? PROD_W'(1) : den_reg;

    // Restoring division of both parts by the common divisor.
    assign g_x = {1'b0, g_reg};
    assign tn  = {remn_reg, quon_reg[PROD_W-1]};
    assign td  = {remd_reg, quod_reg[PROD_W-1]};

    // Final result before the output register.
    always_comb begin
        if (reduce_reg) begin
            num_fin = neg_reg ? -$signed(quon_reg) : $signed(quon_reg);
            den_fin = $signed(quod_reg);
        end else begin
            num_fin = num_reg;
            den_fin = den_reg;
        end
    end

    assign status.reduce   = reduce_reg;
    assign status.gcd_done = (u_reg == '0);

    // Operand, product and canonical-form registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= in_cmd;
            an_reg  <= in_a_num;
            ad_reg  <= in_a_den;
            bn_reg  <= in_b_num;
            bd_reg  <= in_b_den;
            eq_reg  <= (in_a_num == in_b_num) && (in_a_den == in_b_den);
        end
        if (cmd.mul_en) begin
            p_reg[cmd.mul_sel] <= PROD_W'(prod);
        end
        if (cmd.form) begin
            num_reg  <= n_form;
            den_reg  <= d_form;
            form_reg <= form_ok;
        end
        // Zero numerator forces one; a negative denominator hands its sign over.
        if (cmd.fix) begin
            if (d_fix[PROD_W-1]) begin
                num_reg <= -num_reg;
                den_reg <= -d_fix;
            end else begin
                den_reg <= d_fix;
            end
        end
        if (cmd.mag) begin
            neg_reg    <= num_reg[PROD_W-1];
            mag_reg    <= num_reg[PROD_W-1] ? -num_reg : num_reg;
            u_reg      <= num_reg[PROD_W-1] ? -num_reg : num_reg;
            v_reg      <= den_reg;
            k_reg      <= '0;
            reduce_reg <= form_reg && (num_reg != '0) && (den_reg != '0);
        end
        // One binary GCD step per cycle.
        if (cmd.gcd_step) begin
            priority if (!u_reg[0] && !v_reg[0]) begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end else if (!u_reg[0]) begin
                u_reg <= u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_reg <= v_reg >> 1;
            end else if (u_reg >= v_reg) begin
                u_reg <= (u_reg - v_reg) >> 1;
            end else begin
                v_reg <= (v_reg - u_reg) >> 1;
            end
        end
        if (cmd.div_init) begin
            g_reg    <= v_reg << k_reg;
            remn_reg <= '0;
            remd_reg <= '0;
            quon_reg <= mag_reg;
            quod_reg <= den_reg;
        end
        if (cmd.div_step) begin
            if (tn >= g_x) begin
                remn_reg <= PROD_W'(tn - g_x);
                quon_reg <= {quon_reg[PROD_W-2:0], 1'b1};
            end else begin
                remn_reg <= tn[PROD_W-1:0];
                quon_reg <= {quon_reg[PROD_W-2:0], 1'b0};
            end
            if (td >= g_x) begin
                remd_reg <= PROD_W'(td - g_x);
                quod_reg <= {quod_reg[PROD_W-2:0], 1'b1};
            end else begin
                remd_reg <= td[PROD_W-1:0];
                quod_reg <= {quod_reg[PROD_W-2:0], 1'b0};
            end
        end
        // Output word register.
        if (cmd.out_load) begin
            if (form_reg) begin
                rnum_reg <= num_fin[RES_NUM_W-1:0];
                rden_reg <= den_fin[RES_DEN_W-1:0];
                rerr_reg <= (den_fin == '0);
            end else begin
                rnum_reg <= '0;
                rden_reg <= '0;
                rerr_reg <= 1'b0;
            end
            req_reg <= (cmd_reg == CMD_EQ) && eq_reg;
        end
    end

    assign result_num     = rnum_reg;
    assign result_den     = rden_reg;
    assign zero_den_error = rerr_reg;
    assign is_equal       = req_reg;

endmodule

// ===== src/rational_arithmetic_unit_top.sv =====
// Top level of the rational arithmetic unit: stream ports, controller and datapath.
// Depends on rau_pkg, rau_ctrl and rau_dp.
//
//  Channel   Direction  tdata                         tuser
//  s_axis    in         a_num, a_den, b_num, b_den    command
//  m_axis    out        result_num, result_den        zero_den_error, is_equal
//
// A word passes through the products and the sign fix and then, for a valid command
// with both parts nonzero, through the binary GCD loop and the bit-serial divider
// over the 64-bit products.
// Reset (aresetn low at a clock edge) empties the sequencer and the output slot.
// A finished word waits in the output register while m_axis_tready is low; the
// next input word is taken as soon as the sequencer is back in idle.
module rational_arithmetic_unit_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // a_num, a_den, b_num, b_den from bit 0 up, zero padded to bytes
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // command
    input  logic [rau_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // result_num (33 bits), result_den (31 bits) from bit 0 up
    output logic [63:0]                        m_axis_tdata,
    // zero_den_error, is_equal from bit 0 up
    output logic [1:0]                         m_axis_tuser
);
    import rau_pkg::*;

    localparam int W = OPERAND_WIDTH;

    rau_cmd_t    cmd;
    rau_status_t status;
    logic signed [RES_NUM_W-1:0] result_num;
    logic [RES_DEN_W-1:0]        result_den;
    logic                        zero_den_error, is_equal;

    rau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    rau_dp #(.OPERAND_WIDTH(W)) u_dp (
        .aclk           (aclk),
        .in_cmd         (s_axis_tuser),
        .in_a_num       (s_axis_tdata[W-1:0]),
        .in_a_den       (s_axis_tdata[2*W-1:W]),
        .in_b_num       (s_axis_tdata[3*W-1:2*W]),
        .in_b_den       (s_axis_tdata[4*W-1:3*W]),
        .cmd            (cmd),
        .status         (status),
        .result_num     (result_num),
        .result_den     (result_den),
        .zero_den_error (zero_den_error),
        .is_equal       (is_equal)
    );

    assign m_axis_tdata = {result_den, result_num};
    assign m_axis_tuser = {is_equal, zero_den_error};

endmodule

// ===== bench/rational_arithmetic_unit_top_tb.sv =====
// Self-checking bench for the rational arithmetic unit over its stream ports.
// Depends on rau_pkg and rational_arithmetic_unit_top.
`timescale 1ns / 100ps

module rational_arithmetic_unit_top_tb;
    import rau_pkg::*;

    localparam int OPW = 16;
    localparam int TDW = ((4*OPW+7)/8)*8;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 630;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [OPW-1:0]   an;
        logic [OPW-1:0]   ad;
        logic [OPW-1:0]   bn;
        logic [OPW-1:0]   bd;
    } fraction_op_t;

    typedef struct packed {
        logic [RES_NUM_W-1:0] num;
        logic [RES_DEN_W-1:0] den;
        logic                 zde;
        logic                 eq;
    } fraction_res_t;

    // Directed row: operands, and an optional typed-in result.
    typedef struct packed {
        fraction_op_t  op;
        logic          fixed;
        fraction_res_t res;
    } op_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [TDW-1:0] s_axis_tdata = '0;
    logic [CMD_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;

    fraction_res_t pending_results[$];
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int idle_cycles = 0;

    rational_arithmetic_unit_top #(.OPERAND_WIDTH(OPW)) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Greatest common divisor of two nonzero magnitudes.
    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Reduced fraction for one command, all arithmetic wrapped at 64 bits.
    function automatic fraction_res_t reduce_fraction(fraction_op_t op);
        logic signed [63:0] an, ad, bn, bd, n, d, mn;
        logic [63:0] g;
        logic neg;
        fraction_res_t r;
        an = 64'(signed'(op.an));
        ad = 64'(signed'(op.ad));
        bn = 64'(signed'(op.bn));
        bd = 64'(signed'(op.bd));
        r = '0;
        n = 0;
        d = 0;
        case (op.cmd)
            CMD_NORM:  begin n = an; d = ad; end
            CMD_ADD:   begin n = an*bd + bn*ad; d = ad*bd; end
            CMD_SUB:   begin n = an*bd - bn*ad; d = ad*bd; end
            CMD_MUL:   begin n = an*bn; d = ad*bd; end
            CMD_DIV:   begin n = an*bd; d = ad*bn; end
            CMD_RECIP: begin n = ad; d = an; end
            CMD_EQ: begin
                r.eq = (an == bn) && (ad == bd);
                return r;
            end
            default: return r;
        endcase
        if (n == 0) d = 1;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        neg = n < 0;
        mn = neg ? -n : n;
        if (mn != 0 && d != 0) begin
            g = gcd64(mn, d);
            if (g > 1) begin
                mn = mn / g;
                d = d / g;
                n = neg ? -mn : mn;
            end
        end
        r.num = n[RES_NUM_W-1:0];
        r.den = d[RES_DEN_W-1:0];
        r.zde = (d == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("Mismatch on word %0d: %s got %0h expected %0h", words_out, what, got, want);
    endtask

    // Short random gap, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(150, 20);
    endfunction

    // Fractions: mostly small values so that reduction actually happens.
    function automatic logic [OPW-1:0] rand_field();
        int p;
        p = $urandom_range(9);
        if (p < 5) return OPW'($urandom_range(24) - 12);
        if (p < 7) return OPW'($urandom_range(600) - 300);
        if (p < 8) return OPW'($urandom_range(2) == 0 ? 16'h8000 : 16'h7fff);
        return OPW'($urandom);
    endfunction

    // Valid stays high across back-to-back words and drops only for a gap.
    task automatic send_word(fraction_op_t op, fraction_res_t res);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= TDW'({op.bd, op.bn, op.ad, op.an});
        s_axis_tuser <= op.cmd;
        pending_results.push_back(res);
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        words_in++;
    endtask

    // Result side: random back-pressure and field-wise comparison.
    initial begin
        fraction_res_t want, got;
        int g;
        wait (aresetn);
        forever begin
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            got = {m_axis_tdata[32:0], m_axis_tdata[63:33], m_axis_tuser[0], m_axis_tuser[1]};
            if (pending_results.size() == 0) begin
                errors++;
                $display("Unexpected result word %0d", words_out);
            end else begin
                want = pending_results.pop_front();
                if (got.num != want.num) report_mismatch("result_num", got.num, want.num);
                if (got.den != want.den) report_mismatch("result_den", got.den, want.den);
                if (got.zde != want.zde) report_mismatch("zero_den_error", got.zde, want.zde);
                if (got.eq != want.eq) report_mismatch("is_equal", got.eq, want.eq);
            end
            words_out++;
        end
    end

    // Watchdog: cycles without any accepted word on either side.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Watchdog expired with %0d results outstanding", pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Directed rows, then random words, then drain.
    initial begin
        op_row_t rows[$];
        fraction_op_t op;
        fraction_res_t r;
        int p;
        // Expected results given directly where they are obvious.
        rows.push_back({{CMD_NORM, 16'sd4, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
                        {33'sd4, 31'd0, 1'b1, 1'b0}});
        rows.push_back({{CMD_NORM, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
                        {33'sd0, 31'd1, 1'b0, 1'b0}});
        rows.push_back({{CMD_NORM, 16'h8000, 16'h8000, 16'sd0, 16'sd0}, 1'b1,
                        {33'sd1, 31'd1, 1'b0, 1'b0}});
        rows.push_back({{CMD_NORM, 16'h7fff, 16'h8000, 16'sd0, 16'sd0}, 1'b1,
                        {-33'sd32767, 31'd32768, 1'b0, 1'b0}});
        rows.push_back({{CMD_EQ, 16'sd3, 16'sd6, 16'sd3, 16'sd6}, 1'b1,
                        {33'sd0, 31'd0, 1'b0, 1'b1}});
        rows.push_back({{CMD_EQ, 16'sd1, 16'sd2, 16'sd2, 16'sd4}, 1'b1,
                        {33'sd0, 31'd0, 1'b0, 1'b0}});
        rows.push_back({{3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff}, 1'b1, 66'd0});
        rows.push_back({{CMD_RECIP, 16'sd0, 16'sd5, 16'sd0, 16'sd0}, 1'b1,
                        {33'sd5, 31'd0, 1'b1, 1'b0}});
        // Rows left to the predictor.
        rows.push_back({{CMD_NORM, -16'sd6, -16'sd4, 16'sd0, 16'sd0}, 1'b0, 66'd0});
        rows.push_back({{CMD_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3}, 1'b0, 66'd0});
        rows.push_back({{CMD_ADD, 16'sd1, 16'sd2, -16'sd1, 16'sd2}, 1'b0, 66'd0});
        rows.push_back({{CMD_SUB, 16'sd3, 16'sd4, 16'sd1, 16'sd4}, 1'b0, 66'd0});
        rows.push_back({{CMD_MUL, 16'sd2, 16'sd3, -16'sd9, 16'sd4}, 1'b0, 66'd0});
        rows.push_back({{CMD_DIV, 16'sd2, 16'sd3, 16'sd4, -16'sd9}, 1'b0, 66'd0});
        rows.push_back({{CMD_DIV, 16'sd2, 16'sd3, 16'sd0, 16'sd1}, 1'b0, 66'd0});
        rows.push_back({{CMD_RECIP, -16'sd8, 16'sd12, 16'sd0, 16'sd0}, 1'b0, 66'd0});
        rows.push_back({{CMD_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, 66'd0});
        rows.push_back({{CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000}, 1'b0, 66'd0});
        rows.push_back({{CMD_MUL, 16'h8000, 16'sd1, 16'h8000, 16'sd1}, 1'b0, 66'd0});
        rows.push_back({{CMD_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 1'b0, 66'd0});
        rows.push_back({{CMD_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff}, 1'b0, 66'd0});
        rows.push_back({{CMD_ADD, 16'sd5, 16'sd0, 16'sd3, 16'sd0}, 1'b0, 66'd0});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i])
            send_word(rows[i].op, rows[i].fixed ? rows[i].res : reduce_fraction(rows[i].op));

        for (int i = 0; i < N_RANDOM; i++) begin
            op.cmd = CMD_W'($urandom_range(7));
            op.an = rand_field();
            op.ad = rand_field();
            op.bn = rand_field();
            op.bd = rand_field();
            // Equality checks are only interesting when the operands often match.
            p = $urandom_range(3);
            if (op.cmd == CMD_EQ && p != 0) begin
                op.bn = op.an;
                op.bd = (p == 1) ? op.ad : op.ad ^ OPW'(1 << $urandom_range(OPW-1));
            end
            send_word(op, reduce_fraction(op));
        end
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("Sent %0d words over all seven commands and the unused code,", words_in);
        $display("with random gaps and back-pressure; %0d results checked.", words_out);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rau_pkg.sv
src/rau_ctrl.sv
src/rau_dp.sv
src/rational_arithmetic_unit_top.sv
bench/rational_arithmetic_unit_top_tb.sv
